// ----- hw/rtl/oasa_pkg.sv -----
`default_nettype none

package oasa_pkg;

  // arc point width, fixed by the transaction format
  localparam int unsigned PointW = 9;

  // input transaction
  typedef struct packed {
    logic              new_set;
    logic [PointW-1:0] left_point;
    logic [PointW-1:0] right_point;
  } arc_t;

  // result transaction
  typedef struct packed {
    logic [7:0] shelf;
    logic [7:0] arc_index;
    logic       overflow;
  } res_t;

  // control word fields seen by the datapath
  typedef struct packed {
    logic take;     // input transaction accepted this cycle
    logic clr_en;   // count store clearing sweep
    logic scan_en;  // scan of stored arcs
    logic pfx_en;   // prefix pass over shelves
    logic commit;   // store arc and emit result
    logic ovf;      // emit overflow result
  } ctl_t;

  // datapath status used by the jump conditions
  typedef struct packed {
    logic clr_busy;
    logic full;
    logic scan_busy;
    logic pfx_busy;
  } stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/oasa_seq.sv -----
`default_nettype none

module oasa_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  oasa_pkg::stat_t stat_i,
  output oasa_pkg::ctl_t  ctl_o,
  output logic            busy
);
  import oasa_pkg::*;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_CLR,
    C_IDLE,
    C_FULL,
    C_SCAN,
    C_PFX
  } cond_e;

  typedef struct packed {
    logic       busy;
    logic       latch;
    logic       clr_en;
    logic       scan_en;
    logic       pfx_en;
    logic       commit;
    logic       ovf;
    cond_e      cond;
    logic [2:0] target;
  } uword_t;

  localparam logic [2:0] StClear  = 3'd0;
  localparam logic [2:0] StIdle   = 3'd1;
  localparam logic [2:0] StCheck  = 3'd2;
  localparam logic [2:0] StScan   = 3'd3;
  localparam logic [2:0] StPrefix = 3'd4;
  localparam logic [2:0] StCommit = 3'd5;
  localparam logic [2:0] StOvf    = 3'd6;

  // control store: condition true jumps to target, else falls through
  function automatic uword_t ucode_rom(input logic [2:0] addr);
    uword_t w;
    w = '{busy: 1'b1, latch: 1'b0, clr_en: 1'b0, scan_en: 1'b0, pfx_en: 1'b0,
          commit: 1'b0, ovf: 1'b0, cond: C_ALWAYS, target: StIdle};
    unique case (addr)
      StClear: begin
        w.clr_en = 1'b1;
        w.cond   = C_CLR;
        w.target = StClear;
      end
      StIdle: begin
        w.busy   = 1'b0;
        w.latch  = 1'b1;
        w.cond   = C_IDLE;
        w.target = StIdle;
      end
      StCheck: begin
        w.cond   = C_FULL;
        w.target = StOvf;
      end
      StScan: begin
        w.scan_en = 1'b1;
        w.cond    = C_SCAN;
        w.target  = StScan;
      end
      StPrefix: begin
        w.pfx_en = 1'b1;
        w.cond   = C_PFX;
        w.target = StPrefix;
      end
      StCommit: begin
        w.commit = 1'b1;
      end
      StOvf: begin
        w.ovf = 1'b1;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = StIdle;
      end
    endcase
    return w;
  endfunction

  logic [2:0] step_q, step_d;
  uword_t     uw;
  logic       jump;

  assign uw = ucode_rom(step_q);

  // jump condition select
  always_comb begin
    unique case (uw.cond)
      C_ALWAYS: jump = 1'b1;
      C_CLR:    jump = stat_i.clr_busy;
      C_IDLE:   jump = !start;
      C_FULL:   jump = stat_i.full;
      C_SCAN:   jump = stat_i.scan_busy;
      C_PFX:    jump = stat_i.pfx_busy;
      default:  jump = 1'b1;
    endcase
  end

  assign step_d = jump ? uw.target : step_q + 3'd1;

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StClear;
    end else begin
      step_q <= step_d;
    end
  end

  // control word to datapath
  assign ctl_o.take    = uw.latch & start;
  assign ctl_o.clr_en  = uw.clr_en;
  assign ctl_o.scan_en = uw.scan_en;
  assign ctl_o.pfx_en  = uw.pfx_en;
  assign ctl_o.commit  = uw.commit;
  assign ctl_o.ovf     = uw.ovf;
  assign busy          = uw.busy;

endmodule

`default_nettype wire

// ----- hw/rtl/oasa_dp.sv -----
`default_nettype none

module oasa_dp #(
  parameter int unsigned MAX_ARCS = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  oasa_pkg::ctl_t  ctl_i,
  input  oasa_pkg::arc_t  arc_i,
  output oasa_pkg::stat_t stat_o,
  output logic            done_o,
  output oasa_pkg::res_t  result_o
);
  import oasa_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_ARCS);
  localparam int unsigned CntW  = AddrW + 1;

  // circular arc intersection test
  function automatic logic arcs_meet(input logic [PointW-1:0] al, input logic [PointW-1:0] ar,
                                     input logic [PointW-1:0] bl, input logic [PointW-1:0] br);
    logic a_wrap, b_wrap, m;
    a_wrap = al > ar;
    b_wrap = bl > br;
    if (a_wrap && b_wrap) begin
      m = 1'b1;
    end else if (!a_wrap && !b_wrap) begin
      m = (al <= br) && (ar >= bl);
    end else if (a_wrap) begin
      m = !((br < al) && (ar < bl));
    end else begin
      m = !((ar < bl) && (br < al));
    end
    return m;
  endfunction

  arc_t            cur_q;
  logic [CntW-1:0] held_q, held_d;

  // arc store
  logic [PointW-1:0] mem_left_q  [MAX_ARCS];
  logic [PointW-1:0] mem_right_q [MAX_ARCS];
  logic [AddrW-1:0]  mem_shelf_q [MAX_ARCS];
  logic [PointW-1:0] rd_left_q, rd_right_q;
  logic [AddrW-1:0]  rd_shelf_q;

  // per-shelf hit counts
  logic [AddrW-1:0] hits_q [MAX_ARCS];
  logic [AddrW-1:0] hit_rd_q;
  logic             h_we;
  logic [AddrW-1:0] h_wa, h_wd, h_ra;

  // clearing sweep
  logic [CntW-1:0] c_idx_q;
  logic            c_run, c_wr;

  // scan pipeline
  logic [CntW-1:0]  s_idx_q;
  logic             s_issue;
  logic             v1_q, v2_q, hit1;
  logic [AddrW-1:0] a2_q;
  logic             fw_v_q;
  logic [AddrW-1:0] fw_a_q, fw_d_q, hcur, hinc;

  // prefix pass
  logic [CntW-1:0]  p_idx_q;
  logic             p_issue;
  logic             pv_q, found_q;
  logic [AddrW-1:0] pk_q, run_q, run_sum, pick_q;

  logic done_q;
  res_t res_q;

  // clearing sweep runs once after reset
  assign c_run = c_idx_q != CntW'(MAX_ARCS);
  assign c_wr  = ctl_i.clr_en && c_run;

  // scan: issue reads, test intersection, count with forwarding
  assign s_issue = ctl_i.scan_en && (s_idx_q != held_q);
  assign hit1    = v1_q && arcs_meet(rd_left_q, rd_right_q,
                                     cur_q.left_point, cur_q.right_point);
  assign hcur    = (fw_v_q && (fw_a_q == a2_q)) ? fw_d_q : hit_rd_q;
  assign hinc    = hcur + AddrW'(1);

  // prefix: running sum over shelves 0..n
  assign p_issue = ctl_i.pfx_en && (p_idx_q <= held_q);
  assign run_sum = run_q + hit_rd_q;

  // count store port select
  always_comb begin
    h_we = 1'b0;
    h_wa = c_idx_q[AddrW-1:0];
    h_wd = '0;
    if (c_wr) begin
      h_we = 1'b1;
    end else if (v2_q) begin
      h_we = 1'b1;
      h_wa = a2_q;
      h_wd = hinc;
    end else if (p_issue) begin
      h_we = 1'b1;
      h_wa = p_idx_q[AddrW-1:0];
    end
  end
  assign h_ra = ctl_i.pfx_en ? p_idx_q[AddrW-1:0] : rd_shelf_q;

  // count store
  always_ff @(posedge clk_i) begin
    if (h_we) begin
      hits_q[h_wa] <= h_wd;
    end
    hit_rd_q <= hits_q[h_ra];
  end

  // arc store
  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      mem_left_q[held_q[AddrW-1:0]]  <= cur_q.left_point;
      mem_right_q[held_q[AddrW-1:0]] <= cur_q.right_point;
      mem_shelf_q[held_q[AddrW-1:0]] <= pick_q;
    end
    rd_left_q  <= mem_left_q[s_idx_q[AddrW-1:0]];
    rd_right_q <= mem_right_q[s_idx_q[AddrW-1:0]];
    rd_shelf_q <= mem_shelf_q[s_idx_q[AddrW-1:0]];
  end

  // arc count
  always_comb begin
    held_d = held_q;
    if (ctl_i.take && arc_i.new_set) begin
      held_d = '0;
    end else if (ctl_i.commit) begin
      held_d = held_q + CntW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      c_idx_q <= '0;
      s_idx_q <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      fw_v_q  <= 1'b0;
      p_idx_q <= '0;
      pv_q    <= 1'b0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      held_q  <= held_d;
      if (c_wr) begin
        c_idx_q <= c_idx_q + CntW'(1);
      end
      if (!ctl_i.scan_en) begin
        s_idx_q <= '0;
      end else if (s_issue) begin
        s_idx_q <= s_idx_q + CntW'(1);
      end
      v1_q   <= s_issue;
      v2_q   <= hit1;
      fw_v_q <= v2_q;
      if (!ctl_i.pfx_en) begin
        p_idx_q <= '0;
      end else if (p_issue) begin
        p_idx_q <= p_idx_q + CntW'(1);
      end
      pv_q <= p_issue;
      if (!ctl_i.pfx_en) begin
        found_q <= 1'b0;
      end else if (pv_q && !found_q && (run_sum <= pk_q)) begin
        found_q <= 1'b1;
      end
      done_q <= ctl_i.commit | ctl_i.ovf;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.take) begin
      cur_q <= arc_i;
    end
    a2_q   <= rd_shelf_q;
    fw_a_q <= a2_q;
    fw_d_q <= hinc;
    pk_q   <= p_idx_q[AddrW-1:0];
    if (!ctl_i.pfx_en) begin
      run_q <= '0;
    end else if (pv_q) begin
      run_q <= run_sum;
    end
    if (ctl_i.pfx_en && pv_q && !found_q && (run_sum <= pk_q)) begin
      pick_q <= pk_q;
    end
    if (ctl_i.commit) begin
      res_q.shelf     <= 8'(pick_q);
      res_q.arc_index <= 8'(held_q);
      res_q.overflow  <= 1'b0;
    end else if (ctl_i.ovf) begin
      res_q.shelf     <= '0;
      res_q.arc_index <= '0;
      res_q.overflow  <= 1'b1;
    end
  end

  // status to sequencer
  assign stat_o.clr_busy  = c_run;
  assign stat_o.full      = held_q == CntW'(MAX_ARCS);
  assign stat_o.scan_busy = (s_idx_q != held_q) || v1_q || v2_q;
  assign stat_o.pfx_busy  = (p_idx_q <= held_q) || pv_q;

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

// ----- hw/rtl/online_arc_shelf_assigner.sv -----
// channel  | signals                  | handshake
// ---------+--------------------------+-----------------------------------------
// arc in   | start, busy, arc_i       | taken at a clock edge with start && !busy
// result   | done_o, result_o         | one-cycle strobe, cannot be held off
//
// An arc with n arcs already held makes one pass over the arc store, then one
// pass over the shelf counts, each one read port of its memory per cycle,
// before its result strobe. An arc on a full store skips both passes and gives
// its overflow result directly.
// After reset the shelf count memory is cleared over all MAX_ARCS entries;
// busy is high meanwhile. The result stays on result_o until the next one.
`default_nettype none

module online_arc_shelf_assigner #(
  parameter int unsigned MAX_ARCS = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  oasa_pkg::arc_t arc_i,
  output logic           done_o,
  output oasa_pkg::res_t result_o
);
  import oasa_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  // microcode sequencer
  oasa_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .ctl_o  (ctl),
    .busy   (busy)
  );

  // stores, scan and prefix datapath
  oasa_dp #(
    .MAX_ARCS (MAX_ARCS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .arc_i    (arc_i),
    .stat_o   (stat),
    .done_o   (done_o),
    .result_o (result_o)
  );

`ifndef SYNTHESIS
  // one result per transaction, never back to back
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe high two cycles in a row");

  // an accepted transaction keeps the block busy
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("not busy after accepting a transaction");

  // overflow results carry zero shelf and index
  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.overflow) |->
      (result_o.shelf == 8'd0 && result_o.arc_index == 8'd0))
    else $error("overflow result with nonzero fields");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/online_arc_shelf_assigner_tb.sv -----
`timescale 1ns / 100ps

module online_arc_shelf_assigner_tb;
  import oasa_pkg::*;

  localparam int unsigned ArcSlots  = 256;
  localparam int unsigned CirclePts = 360;
  localparam int unsigned PointMax  = (1 << PointW) - 1;
  localparam int unsigned DrainCap  = 8 * ArcSlots + 100;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  arc_t arc_i;
  logic done_o;
  res_t result_o;

  online_arc_shelf_assigner #(
    .MAX_ARCS(ArcSlots)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .arc_i   (arc_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // predictor copy of the arc store
  logic [PointW-1:0] held_left [ArcSlots];
  logic [PointW-1:0] held_right[ArcSlots];
  int unsigned       held_shelf[ArcSlots];
  int unsigned       held_count = 0;

  res_t pending_results[$];

  int unsigned error_count     = 0;
  int unsigned arcs_sent       = 0;
  int unsigned results_checked = 0;
  int unsigned overflows_seen  = 0;
  int unsigned top_shelf_seen  = 0;
  int unsigned top_index_seen  = 0;
  bit          quiet_sender    = 1'b0;

  // closed-range overlap on the circle, wrap when left > right
  function automatic bit arcs_cross(logic [PointW-1:0] al, logic [PointW-1:0] ar,
                                    logic [PointW-1:0] bl, logic [PointW-1:0] br);
    bit a_wrap;
    bit b_wrap;
    a_wrap = al > ar;
    b_wrap = bl > br;
    if (a_wrap && b_wrap) return 1'b1;
    if (!a_wrap && !b_wrap) return (al <= br) && (ar >= bl);
    if (a_wrap) return !((br < al) && (ar < bl));
    return !((ar < bl) && (br < al));
  endfunction

  // count crossings per shelf, take smallest shelf s with prefix sum <= s
  function automatic res_t assign_shelf(arc_t a);
    res_t        r;
    int unsigned hits[ArcSlots];
    int unsigned n;
    int unsigned k;
    int unsigned run;
    int unsigned pick;
    r = '0;
    if (a.new_set) held_count = 0;
    if (held_count >= ArcSlots) begin
      r.overflow = 1'b1;
      return r;
    end
    n = held_count;
    for (k = 0; k < ArcSlots; k++) hits[k] = 0;
    for (k = 0; k < n; k++) begin
      if (arcs_cross(held_left[k], held_right[k], a.left_point, a.right_point)) begin
        hits[held_shelf[k]]++;
      end
    end
    pick = n;
    run  = 0;
    for (k = 0; k <= n; k++) begin
      run += hits[k];
      if (run <= k && k < pick) pick = k;
    end
    held_left[n]  = a.left_point;
    held_right[n] = a.right_point;
    held_shelf[n] = pick;
    held_count    = n + 1;
    r.shelf       = pick[7:0];
    r.arc_index   = n[7:0];
    return r;
  endfunction

  function automatic arc_t make_arc(bit fresh, int unsigned l, int unsigned r);
    arc_t a;
    a.new_set     = fresh;
    a.left_point  = l[PointW-1:0];
    a.right_point = r[PointW-1:0];
    return a;
  endfunction

  // mostly short plain arcs so shelves spread, some wraps and raw 9-bit noise
  function automatic arc_t random_arc(bit fresh);
    arc_t        a;
    int unsigned sel;
    int unsigned len;
    a.new_set = fresh;
    sel = $urandom_range(99);
    if (sel < 50) begin
      len           = $urandom_range(0, 40);
      a.left_point  = PointW'($urandom_range(0, CirclePts - 1 - len));
      a.right_point = a.left_point + PointW'(len);
    end else if (sel < 70) begin
      a.left_point  = PointW'($urandom_range(0, CirclePts - 1));
      a.right_point = PointW'($urandom_range(a.left_point, CirclePts - 1));
    end else if (sel < 92) begin
      a.left_point  = PointW'($urandom_range(1, CirclePts - 1));
      a.right_point = PointW'($urandom_range(0, a.left_point - 1));
    end else begin
      a.left_point  = PointW'($urandom_range(0, PointMax));
      a.right_point = PointW'($urandom_range(0, PointMax));
    end
    return a;
  endfunction

  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= 10) $display("mismatch: %s", what);
  endtask

  // one arc transaction, then maybe a random gap reaching into the busy window
  task automatic send_arc(input arc_t a);
    int unsigned gap;
    start <= 1'b1;
    arc_i <= a;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    pending_results.push_back(assign_shelf(a));
    arcs_sent++;
    if (!quiet_sender && $urandom_range(99) < 15) begin
      gap = $urandom_range(1, 2 * held_count + 12);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold off the sender until every expected result is in
  task automatic wait_all_results();
    int unsigned guard;
    guard = 0;
    start <= 1'b0;
    while (pending_results.size() != 0 && guard < DrainCap) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (2 * ArcSlots + 16) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result with nothing expected: shelf %0d index %0d ovf %0b",
                             result_o.shelf, result_o.arc_index, result_o.overflow));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (result_o.shelf !== want.shelf)
          flag_error($sformatf("shelf exp %0d got %0d", want.shelf, result_o.shelf));
        if (result_o.arc_index !== want.arc_index)
          flag_error($sformatf("arc_index exp %0d got %0d", want.arc_index,
                               result_o.arc_index));
        if (result_o.overflow !== want.overflow)
          flag_error($sformatf("overflow exp %0b got %0b", want.overflow,
                               result_o.overflow));
        if (want.overflow) overflows_seen++;
        if (want.shelf > top_shelf_seen) top_shelf_seen = want.shelf;
        if (want.arc_index > top_index_seen) top_index_seen = want.arc_index;
      end
    end
  end

  // endpoints, touching ranges, gaps, wraps and points beyond the circle
  task automatic test_directed_edges();
    send_arc(make_arc(1, 0, 0));
    send_arc(make_arc(0, 359, 359));
    send_arc(make_arc(0, 0, 359));
    send_arc(make_arc(0, 359, 0));
    send_arc(make_arc(0, 200, 100));
    send_arc(make_arc(0, 150, 150));
    send_arc(make_arc(0, 101, 199));
    send_arc(make_arc(0, 100, 199));
    send_arc(make_arc(0, 1, 0));
    send_arc(make_arc(0, PointMax, 0));
    send_arc(make_arc(0, 360, PointMax));
    send_arc(make_arc(1, PointMax, PointMax));
    send_arc(make_arc(0, 256, 255));
    send_arc(make_arc(1, 10, 20));
    send_arc(make_arc(0, 20, 30));
    send_arc(make_arc(0, 31, 40));
    send_arc(make_arc(0, 5, 9));
    send_arc(make_arc(1, 0, 0));
    send_arc(make_arc(1, 0, 0));
    send_arc(make_arc(0, 300, 50));
    send_arc(make_arc(0, 280, 40));
  endtask

  // wrapping arcs always cross, so shelves climb to the top; then overflow
  task automatic test_full_store();
    int unsigned i;
    int unsigned l;
    for (i = 0; i < ArcSlots; i++) begin
      l = $urandom_range(1, CirclePts - 1);
      send_arc(make_arc(i == 0, l, $urandom_range(0, l - 1)));
    end
    send_arc(make_arc(0, 0, 359));
    send_arc(make_arc(0, 300, 10));
    send_arc(make_arc(0, PointMax, PointMax));
    send_arc(make_arc(1, 42, 43));
  endtask

  // random sets, mostly small, one larger run and one quiet stretch
  task automatic test_random_sets(input int unsigned count);
    int unsigned i;
    bit          fresh;
    for (i = 0; i < count; i++) begin
      quiet_sender = (i >= 200 && i < 300);
      if (i >= 380 && i < 500) fresh = ($urandom_range(99) == 0);
      else fresh = ($urandom_range(11) == 0);
      if (i == 330) wait_all_results();
      send_arc(random_arc(fresh));
    end
    quiet_sender = 1'b0;
  endtask

  initial begin
    rst_ni <= 1'b0;
    start  <= 1'b0;
    arc_i  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_edges();
    wait_all_results();
    test_full_store();
    wait_all_results();
    test_random_sets(520);
    wait_all_results();
    if (pending_results.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
      error_count += pending_results.size() - 1;
    end
    $display("sent %0d arcs, checked %0d results, %0d overflow results",
             arcs_sent, results_checked, overflows_seen);
    $display("highest shelf %0d, highest arc index %0d, %0d errors",
             top_shelf_seen, top_index_seen, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
